@@ rtl/ktk_pkg.sv @@
// ----------------------------------------------------------------------------
// ktk_pkg - shared types for the streaming top-K selector
// Word formats of the input and result channels and the link record that
// passes between neighboring cells of the sorted chain.
// ----------------------------------------------------------------------------
package ktk_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic        [COUNT_W-1:0] count_t;

    // Input word: one value of the data set.
    typedef struct packed {
        value_t value;
        logic   first_of_set;
    } ktk_in_t;

    // Result word: smallest kept value and the number of kept values.
    typedef struct packed {
        value_t kth_value;
        count_t kept;
    } ktk_out_t;

    // Link from cell i to cell i+1: the value cell i holds, and whether the
    // new value lands at or before cell i (so cell i+1 shifts down).
    typedef struct packed {
        value_t value;
        logic   take;
    } ktk_link_t;

endpackage

@@ rtl/ktk_cell.sv @@
// ----------------------------------------------------------------------------
// ktk_cell - one slot of the descending sorted chain
// Holds one kept value. On an insert it either keeps its value, takes the
// new value, or takes its upper neighbor's value to shift down one place.
// ----------------------------------------------------------------------------
module ktk_cell (
    input  logic              clk,
    input  logic              shift_en,
    input  logic              live,
    input  ktk_pkg::value_t   new_value,
    input  ktk_pkg::ktk_link_t prev,
    output ktk_pkg::ktk_link_t link
);
    import ktk_pkg::*;

    value_t value_reg;
    value_t value_next;
    logic   take;

    // The new value goes here or above when this slot is empty or it beats
    // the value held; order is descending so this flag is monotone down the row.
    assign take = !live || (new_value > value_reg);

    always_comb
    begin
        value_next = value_reg;
        if (take)
        begin
            value_next = prev.take ? prev.value : new_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            value_reg <= value_next;
        end
    end

    assign link.value = value_reg;
    assign link.take  = take;

endmodule

@@ rtl/kth_largest_top_k.sv @@
// ----------------------------------------------------------------------------
// kth_largest_top_k - streaming top-K selection
// Keeps the K largest signed values of the current data set in a row of
// sorted cells and reports, per input word, the K-th largest and the count.
// ----------------------------------------------------------------------------
//
//  channel   signals                        direction  word
//  -------   ----------------------------   ---------  -------------------------
//  src       src_valid src_ready src_data   in         value, first_of_set
//  res       res_valid res_ready res_data   out        kth_value, kept
//  cfg       cfg_we cfg_wdata               in         keep_count (K), no wait
//
//  One input word per cycle is sustained while res_ready stays high; the cell
//  row updates at the accepting edge and the result register loads from the
//  row once the old result has been taken.
//  The cell row compares every slot against the new value in parallel, so the
//  insert time does not grow with K.
//  Reset clears the count, busy flag, result valid and sets K to 1; the cell
//  values are not reset (only the first kept_count slots are ever read).
//  A stalled result register holds; the row then holds one word and src stalls.
// ----------------------------------------------------------------------------
module kth_largest_top_k #(
    parameter int CAPACITY = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             src_valid,
    output logic             src_ready,
    input  ktk_pkg::ktk_in_t src_data,
    output logic             res_valid,
    input  logic             res_ready,
    output ktk_pkg::ktk_out_t res_data,
    input  logic             cfg_we,
    input  ktk_pkg::count_t  cfg_wdata
);
    import ktk_pkg::*;

    // Largest K reachable: the row size, or what the count field can carry.
    localparam int     MAX_K     = (CAPACITY > (1 << COUNT_W) - 1) ?
                                   (1 << COUNT_W) - 1 : CAPACITY;
    localparam count_t CAP_CLAMP = COUNT_W'(MAX_K);

    count_t    keep_count_reg;
    count_t    held_reg;
    count_t    held_next;
    count_t    held_base;
    count_t    k_eff;
    logic      busy_reg;
    logic      busy_next;
    logic      res_valid_reg;
    logic      res_valid_next;
    ktk_out_t  res_reg;
    ktk_out_t  res_next;
    logic      src_fire;
    logic      res_load;
    value_t    tail_value;

    ktk_link_t links [0:CAPACITY];
    logic      live_eff [0:CAPACITY-1];
    logic      live_now [0:CAPACITY-1];
    logic      last_now [0:CAPACITY-1];

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg <= COUNT_W'(1);
        end
        else if (cfg_we)
        begin
            keep_count_reg <= cfg_wdata;
        end
    end

    // Clamp K: zero acts as one, anything above the row acts as the row size.
    always_comb
    begin
        if (keep_count_reg == '0)
        begin
            k_eff = COUNT_W'(1);
        end
        else if (keep_count_reg > CAP_CLAMP)
        begin
            k_eff = CAP_CLAMP;
        end
        else
        begin
            k_eff = keep_count_reg;
        end
    end

    // ------------------------------------------------------------- handshake
    // Load the result register from the row once an insert is in flight, as
    // soon as the old result is gone. A new word may enter in that same cycle.
    assign res_load  = busy_reg && (!res_valid_reg || res_ready);
    assign src_ready = !busy_reg || res_load;
    assign src_fire  = src_valid && src_ready;

    // ------------------------------------------------------------ held count
    // Drop everything on a new set, trim to K, then add one up to K.
    always_comb
    begin
        if (src_data.first_of_set)
        begin
            held_base = '0;
        end
        else if (held_reg > k_eff)
        begin
            held_base = k_eff;
        end
        else
        begin
            held_base = held_reg;
        end

        if (held_base < k_eff)
        begin
            held_next = held_base + COUNT_W'(1);
        end
        else
        begin
            held_next = k_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else if (src_fire)
        begin
            held_reg <= held_next;
        end
    end

    // ------------------------------------------------------------- cell row
    assign links[0] = '{value: '0, take: 1'b0};

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        // Slot counts as occupied only inside the trimmed, uncleared prefix.
        assign live_now[i] = (32'(i) < 32'(held_reg));
        assign live_eff[i] = live_now[i] && !src_data.first_of_set &&
                             (32'(i) < 32'(k_eff));

        if (i == CAPACITY - 1)
        begin : g_end
            assign last_now[i] = live_now[i];
        end
        else
        begin : g_mid
            assign last_now[i] = live_now[i] && !(32'(i + 1) < 32'(held_reg));
        end

        ktk_cell u_cell (
            .clk       (clk),
            .shift_en  (src_fire),
            .live      (live_eff[i]),
            .new_value (src_data.value),
            .prev      (links[i]),
            .link      (links[i+1])
        );
    end

    // Pick the tail of the occupied prefix: exactly one slot is flagged once a value is held.
    always_comb
    begin
        tail_value = '0;
        for (int j = 0; j < CAPACITY; j++)
        begin
            if (last_now[j])
            begin
                tail_value = tail_value | links[j+1].value;
            end
        end
    end

    // -------------------------------------------------------- result register
    always_comb
    begin
        busy_next      = busy_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end
        if (res_load)
        begin
            res_valid_next     = 1'b1;
            res_next.kth_value = tail_value;
            res_next.kept      = held_reg;
            busy_next          = 1'b0;
        end
        if (src_fire)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

`ifndef SYNTH
    // A delivered result always reports at least one kept value.
    a_kept_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_reg.kept != '0))
        else $error("result with zero kept values");

    // A word that opens a set leaves exactly one value held.
    a_new_set_one: assert property (@(posedge clk) disable iff (!rst_n)
        (src_fire && src_data.first_of_set) |=> (held_reg == COUNT_W'(1)))
        else $error("new set did not restart the count");

    // An accepted word sets the busy flag, which marks the word as in flight
    // in the row until the result register loads it.
    a_busy_after_fire: assert property (@(posedge clk) disable iff (!rst_n)
        src_fire |=> busy_reg)
        else $error("accepted word not marked in flight");

    // The held count never exceeds the row or K after an insert.
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        src_fire |=> (held_reg <= $past(k_eff)) && (32'(held_reg) <= 32'(CAPACITY)))
        else $error("held count beyond K");

    // A result load always leaves the result register valid.
    a_res_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> res_valid_reg)
        else $error("result load lost");
`endif

endmodule
